// File: src/stwq_pkg.sv
// ----------------------------------------------------------------------------
// stwq_pkg
// Shared types, widths and helpers for the semaphore timed wait queue.
// ----------------------------------------------------------------------------
package stwq_pkg;

  localparam int unsigned MAX_WAITERS = 16;
  localparam int unsigned AW          = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int unsigned CW          = $clog2(MAX_WAITERS + 1);

  localparam int unsigned ID_W   = 16;
  localparam int unsigned TIME_W = 16;
  localparam int unsigned RCNT_W = 5;

  typedef enum logic [1:0] {
    CMD_ENQ     = 2'd0,
    CMD_SIGNAL  = 2'd1,
    CMD_REL_ALL = 2'd2,
    CMD_TICK    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CAUSE_SIGNAL  = 2'd0,
    CAUSE_TIMEOUT = 2'd1,
    CAUSE_REL_ALL = 2'd2
  } cause_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] timer;
  } entry_t;

  typedef struct packed {
    logic              released_valid;
    logic [ID_W-1:0]   released_id;
    cause_e            release_cause;
    logic [RCNT_W-1:0] released_count;
    logic              queue_full;
    logic              last;
  } rel_t;

  // Ring index add, both operands below MAX_WAITERS
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (AW + 1)'(MAX_WAITERS)) begin
      sum = sum - (AW + 1)'(MAX_WAITERS);
    end
    return sum[AW-1:0];
  endfunction

endpackage

// File: src/stwq_ifs.sv
// ----------------------------------------------------------------------------
// stwq_ifs
// Valid/ready channels for commands and release beats.
// ----------------------------------------------------------------------------
interface stwq_cmd_if import stwq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [ID_W-1:0]   thread_id;
  logic [TIME_W-1:0] wait_time;

  modport source (output valid, command, thread_id, wait_time, input ready);
  modport sink   (input valid, command, thread_id, wait_time, output ready);
endinterface

interface stwq_rel_if import stwq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              released_valid;
  logic [ID_W-1:0]   released_id;
  logic [1:0]        release_cause;
  logic [RCNT_W-1:0] released_count;
  logic              queue_full;
  logic              last;

  modport source (output valid, released_valid, released_id, release_cause,
                  released_count, queue_full, last, input ready);
  modport sink   (input valid, released_valid, released_id, release_cause,
                  released_count, queue_full, last, output ready);
endinterface

// File: src/semaphore_timed_wait_queue.sv
// ----------------------------------------------------------------------------
// semaphore_timed_wait_queue
// FIFO of threads blocked on a semaphore, with per-waiter timeout.
// ----------------------------------------------------------------------------
// Waiters live in a ring buffer in one synchronous memory (one write and one
// read port, registered read data), addressed from a head pointer. Commands
// are taken one at a time. Enqueue and commands on an empty queue finish in
// the dispatch state; signal reads the head entry, then releases it. Release-all
// and tick walk the queue through the single read port, one entry per cycle
// while the output is not stalled; tick then ends with a closing beat. Tick
// writes surviving entries back in place, packed toward the head.
// Every command yields at least one release beat; the final one has last set.
// ----------------------------------------------------------------------------
module semaphore_timed_wait_queue import stwq_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  stwq_cmd_if.sink     cmd_i,
  stwq_rel_if.source   rel_o
);

  state_e            state_q, state_d;
  logic [AW-1:0]     head_q, head_d;
  logic [CW-1:0]     count_q, count_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     keep_q, keep_d;
  logic [CW-1:0]     n_q, n_d;
  logic              pend_v_q, pend_v_d;
  logic [ID_W-1:0]   pend_id_q, pend_id_d;
  logic [CW-1:0]     pend_n_q, pend_n_d;
  logic              out_valid_q, out_valid_d;
  rel_t              out_q, out_d;

  cmd_e              cmd_q;
  logic [ID_W-1:0]   tid_q;
  logic [TIME_W-1:0] wt_q;

  entry_t            mem_q [MAX_WAITERS];
  entry_t            rdata_q;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              we;
  logic [AW-1:0]     waddr;
  entry_t            wdata;

  logic              cmd_acc;
  logic              out_free;
  logic              at_end;
  logic              expire;
  logic [TIME_W-1:0] t_dec;
  logic              emit;
  rel_t              emit_data;

  assign cmd_acc   = cmd_i.valid & cmd_i.ready;
  assign cmd_i.ready = (state_q == S_IDLE);
  assign out_free  = ~out_valid_q | rel_o.ready;
  assign at_end    = (CW'(idx_q) + CW'(1)) == count_q;
  assign expire    = rdata_q.timer == TIME_W'(1);
  assign t_dec     = (rdata_q.timer == '0) ? '0 : rdata_q.timer - TIME_W'(1);

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    idx_d     = idx_q;
    keep_d    = keep_q;
    n_d       = n_q;
    pend_v_d  = pend_v_q;
    pend_id_d = pend_id_q;
    pend_n_d  = pend_n_q;
    rd_en     = 1'b0;
    rd_addr   = wrap_add(head_q, idx_q + AW'(1));
    we        = 1'b0;
    waddr     = wrap_add(head_q, keep_q[AW-1:0]);
    wdata     = '{id: rdata_q.id, timer: t_dec};
    emit      = 1'b0;
    emit_data = '{released_valid: 1'b0, released_id: '0, release_cause: CAUSE_SIGNAL,
                  released_count: '0, queue_full: 1'b0, last: 1'b1};

    case (state_q)
      S_IDLE: begin
        if (cmd_acc) begin
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (cmd_q == CMD_ENQ) begin
          if (out_free) begin
            emit = 1'b1;
            if (count_q < CW'(MAX_WAITERS)) begin
              we      = 1'b1;
              waddr   = wrap_add(head_q, count_q[AW-1:0]);
              wdata   = '{id: tid_q, timer: wt_q};
              count_d = count_q + CW'(1);
            end else begin
              emit_data.queue_full = 1'b1;
            end
            state_d = S_IDLE;
          end
        end else if (count_q == '0) begin
          if (out_free) begin
            emit    = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          rd_en    = 1'b1;
          rd_addr  = head_q;
          idx_d    = '0;
          keep_d   = '0;
          n_d      = '0;
          pend_v_d = 1'b0;
          state_d  = S_SCAN;
        end
      end
      S_SCAN: begin
        case (cmd_q)
          CMD_SIGNAL: begin
            if (out_free) begin
              emit      = 1'b1;
              emit_data = '{released_valid: 1'b1, released_id: rdata_q.id,
                            release_cause: CAUSE_SIGNAL, released_count: RCNT_W'(1),
                            queue_full: 1'b0, last: 1'b1};
              head_d    = wrap_add(head_q, AW'(1));
              count_d   = count_q - CW'(1);
              state_d   = S_IDLE;
            end
          end
          CMD_REL_ALL: begin
            if (out_free) begin
              emit      = 1'b1;
              emit_data = '{released_valid: 1'b1, released_id: rdata_q.id,
                            release_cause: CAUSE_REL_ALL,
                            released_count: RCNT_W'(n_q + CW'(1)),
                            queue_full: 1'b0, last: at_end};
              n_d       = n_q + CW'(1);
              if (at_end) begin
                count_d = '0;
                state_d = S_IDLE;
              end else begin
                idx_d = idx_q + AW'(1);
                rd_en = 1'b1;
              end
            end
          end
          CMD_TICK: begin
            if (!(expire && pend_v_q && !out_free)) begin
              if (expire) begin
                if (pend_v_q) begin
                  emit      = 1'b1;
                  emit_data = '{released_valid: 1'b1, released_id: pend_id_q,
                                release_cause: CAUSE_TIMEOUT,
                                released_count: RCNT_W'(pend_n_q),
                                queue_full: 1'b0, last: 1'b0};
                end
                pend_v_d  = 1'b1;
                pend_id_d = rdata_q.id;
                pend_n_d  = n_q + CW'(1);
                n_d       = n_q + CW'(1);
              end else begin
                we     = 1'b1;
                keep_d = keep_q + CW'(1);
              end
              if (at_end) begin
                state_d = S_FIN;
              end else begin
                idx_d = idx_q + AW'(1);
                rd_en = 1'b1;
              end
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_FIN: begin
        if (out_free) begin
          emit = 1'b1;
          if (pend_v_q) begin
            emit_data = '{released_valid: 1'b1, released_id: pend_id_q,
                          release_cause: CAUSE_TIMEOUT,
                          released_count: RCNT_W'(pend_n_q),
                          queue_full: 1'b0, last: 1'b1};
          end
          count_d = keep_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = emit_data;
    end else if (rel_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      keep_q      <= '0;
      n_q         <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      keep_q      <= keep_d;
      n_q         <= n_d;
      pend_v_q    <= pend_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_id_q <= pend_id_d;
    pend_n_q  <= pend_n_d;
    out_q     <= out_d;
    if (cmd_acc) begin
      cmd_q <= cmd_e'(cmd_i.command);
      tid_q <= cmd_i.thread_id;
      wt_q  <= cmd_i.wait_time;
    end
  end

  // waiter memory
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign rel_o.valid          = out_valid_q;
  assign rel_o.released_valid = out_q.released_valid;
  assign rel_o.released_id    = out_q.released_id;
  assign rel_o.release_cause  = out_q.release_cause;
  assign rel_o.released_count = out_q.released_count;
  assign rel_o.queue_full     = out_q.queue_full;
  assign rel_o.last           = out_q.last;

  // write-back only targets entries already read
  a_no_rw_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && rd_en) |-> (waddr != rd_addr))
    else $error("read and write hit the same waiter entry");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_WAITERS))
    else $error("waiter count above capacity");

  a_keep_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (keep_q <= CW'(idx_q)))
    else $error("compaction pointer ahead of scan");

  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_acc |=> (state_q == S_DISPATCH))
    else $error("accepted command not dispatched");

  a_full_only_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.queue_full) |-> (!out_q.released_valid && out_q.last))
    else $error("queue_full on a release beat");

endmodule
